[hw/rtl/utd_pkg.sv]
// Shared types, constants and decode helpers for the UTF-8 to code point decoder.
// Depends on nothing; every other file of the block but the checker imports it.
package utd_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int PEND_W = 3;

  localparam logic [CODE_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    logic              has_code;
    logic              string_done;
  } res_item_t;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_INVALID
  } lead_class_t;

  function automatic lead_class_t classify_lead(input logic [BYTE_W-1:0] b);
    lead_class_t cls;
    priority if (b[7] == 1'b0) begin
      cls = LEAD_ASCII;
    end else if ((b & 8'hE0) == 8'hC0) begin
      cls = LEAD_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      cls = LEAD_THREE;
    end else begin
      cls = LEAD_INVALID;
    end
    return cls;
  endfunction

  // Number of bytes discarded after an invalid or unsupported lead byte.
  function automatic logic [PEND_W-1:0] skip_count(input logic [BYTE_W-1:0] b);
    logic [PEND_W-1:0] n;
    priority if ((b & 8'hF8) == 8'hF0) begin
      n = 3'd3;
    end else if ((b & 8'hFC) == 8'hF8) begin
      n = 3'd4;
    end else if ((b & 8'hFE) == 8'hFC) begin
      n = 3'd5;
    end else if (b == 8'hFE) begin
      n = 3'd6;
    end else if (b == 8'hFF) begin
      n = 3'd7;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

endpackage

[hw/rtl/utd_in_stage.sv]
// Input register of the UTF-8 decoder: captures one item per cycle while not stalled.
// Depends on utd_pkg for the item type.
module utd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  utd_pkg::in_item_t in_item,
  input  logic              dn_ready,
  output logic              s1_valid,
  output utd_pkg::in_item_t s1_item
);
  import utd_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     load;

  assign in_stall = s1_valid_r && !dn_ready;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

[hw/rtl/utd_dec_unit.sv]
// Decode logic and sequence state of the UTF-8 decoder.
// Depends on utd_pkg for types, constants and the lead byte helpers.
module utd_dec_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  utd_pkg::in_item_t  item,
  output utd_pkg::res_item_t res
);
  import utd_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              skip_r, skip_nxt;
  logic [CODE_W-1:0] part_r, part_nxt;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic              emit;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] cont_hi;
  logic [CODE_W-1:0] cont_lo;
  logic [PEND_W-1:0] skip_n;

  assign b       = item.byte_in;
  assign last    = item.end_of_string;
  assign cont_hi = {4'd0, b[5:0], 6'd0};
  assign cont_lo = {10'd0, b[5:0]};
  assign skip_n  = skip_count(b);

  always_comb begin
    pend_nxt = pend_r;
    skip_nxt = skip_r;
    part_nxt = part_r;
    emit     = 1'b0;
    code     = '0;
    if (pend_r != '0) begin
      if (skip_r) begin
        pend_nxt = pend_r - 3'd1;
        if (pend_nxt == '0) begin
          skip_nxt = 1'b0;
        end
      end else if (pend_r >= 3'd2) begin
        part_nxt = part_r | cont_hi;
        pend_nxt = 3'd1;
        if (last) begin
          emit = 1'b1;
          code = part_nxt;
        end
      end else begin
        emit     = 1'b1;
        code     = part_r | cont_lo;
        pend_nxt = '0;
        part_nxt = '0;
      end
    end else begin
      unique case (classify_lead(b))
        LEAD_ASCII: begin
          emit = 1'b1;
          code = {8'd0, b};
        end
        LEAD_TWO: begin
          part_nxt = {5'd0, b[4:0], 6'd0};
          pend_nxt = 3'd1;
          if (last) begin
            emit = 1'b1;
            code = part_nxt;
          end
        end
        LEAD_THREE: begin
          part_nxt = {b[3:0], 12'd0};
          pend_nxt = 3'd2;
          if (last) begin
            emit = 1'b1;
            code = part_nxt;
          end
        end
        default: begin
          emit     = 1'b1;
          code     = REPLACEMENT_CHAR;
          pend_nxt = skip_n;
          skip_nxt = (skip_n != '0);
          part_nxt = '0;
        end
      endcase
    end
    // The end of a string always leaves a clean state for the next one.
    if (last) begin
      pend_nxt = '0;
      skip_nxt = 1'b0;
      part_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      skip_r <= 1'b0;
      part_r <= '0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      skip_r <= skip_nxt;
      part_r <= part_nxt;
    end
  end

  assign res.code_point  = emit ? code : '0;
  assign res.has_code    = emit;
  assign res.string_done = last;

endmodule

[hw/rtl/utd_out_stage.sv]
// Result register of the UTF-8 decoder: holds one result until it is taken.
// Depends on utd_pkg for the result type.
module utd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  utd_pkg::res_item_t res,
  output logic               dn_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output utd_pkg::res_item_t out_item
);
  import utd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  res_item_t out_item_r;

  assign dn_ready = !out_valid_r || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/utf8_to_codepoint_decoder_core.sv]
// UTF-8 to code point decoder, top level: one byte in, one result out per item.
// An item is captured in the input register, decoded as it moves on, and its result is
// registered in the output register, which drives the out_ ports.
// Throughput: one item per cycle while out_stall is low, set by the input register feeding the decode logic.
// Reset (rst_n low, synchronous) empties both registers and clears the sequence state.
// Depends on utd_pkg, utd_in_stage, utd_dec_unit and utd_out_stage.
module utf8_to_codepoint_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_point,
  output logic        out_has_code,
  output logic        out_string_done
);
  import utd_pkg::*;

  in_item_t  in_item;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      dn_ready;
  logic      advance;
  res_item_t dec_res;
  res_item_t out_item;

  // Bundle the input fields into one item for the input register.
  assign in_item.byte_in       = in_byte_in;
  assign in_item.end_of_string = in_end_of_string;

  // The input register takes a new item whenever its current one moves on, so a
  // waiting result in the output register does not block the next byte unless
  // both registers are full.
  utd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .dn_ready (dn_ready),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // An item is decoded, and the sequence state updated, in the cycle in which it
  // moves from the input register to the output register.
  assign advance = s1_valid && dn_ready;

  utd_dec_unit u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item),
    .res     (dec_res)
  );

  // The output register holds the result stable for as long as it is stalled.
  utd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (dec_res),
    .dn_ready  (dn_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_code_point  = out_item.code_point;
  assign out_has_code    = out_item.has_code;
  assign out_string_done = out_item.string_done;

endmodule

[hw/rtl/utd_checker.sv]
// Port-level checks for the UTF-8 decoder, bound to the top level below.
// Depends on the top level's port list only.
module utd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte_in,
  input logic        in_end_of_string,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code_point,
  input logic        out_has_code,
  input logic        out_string_done
);

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte_in) && $stable(in_end_of_string))
    else $error("stalled input item changed");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_code_point) && $stable(out_has_code)
      && $stable(out_string_done))
    else $error("stalled result changed");

  // Reset leaves no result offered.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A result without a completed character carries a zero code point.
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_code |-> out_code_point == 16'd0)
    else $error("code point set without a character");

endmodule

bind utf8_to_codepoint_decoder_core utd_checker u_utd_checker (.*);
